FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All checks sample on clk and are quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bda_pkg.sv
package bda_pkg;

    // Field widths
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned RATE_W     = 10;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_TDATA_W = 40;

    // Repeat interval = TICKS_PER_SECOND / rate
    localparam logic [RATE_W-1:0] TICKS_PER_SECOND = RATE_W'(1000);
    localparam int unsigned       DIV_STEPS        = RATE_W;
    localparam int unsigned       DIV_CNT_W        = $clog2(DIV_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RATE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE        = 2'd3;

    // Reset values
    localparam logic [MS_W-1:0]   RST_DEBOUNCE_MS     = MS_W'(50);
    localparam logic [MS_W-1:0]   RST_FIRST_REPEAT_MS = MS_W'(500);
    localparam logic [RATE_W-1:0] RST_REPEAT_RATE     = RATE_W'(10);
    localparam logic [RATE_W-1:0] RST_REPEAT_INTERVAL = RATE_W'(100);
    localparam logic [CODE_W-1:0] RST_KEY_CODE        = CODE_W'(1);

    // Settings seen by the per-poll logic
    typedef struct packed {
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   first_repeat_ms;
        logic [RATE_W-1:0] repeat_interval;
        logic [CODE_W-1:0] key_code;
    } bda_cfg_t;

endpackage

FILE: rtl/button_debounce_autorepeat_top.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   raw_level, now_ms
// m_axis    out  m_axis_tvalid/m_axis_tready   event_code
// cfg       in   cfg_wr_en                     cfg_index, cfg_data
//
// One poll per cycle while s_axis_tready is high; one result per poll.
// Path: input register, debounce/repeat compare logic, result register.
// A repeat rate write starts a restoring divide; s_axis_tready is low
// until it finishes. Other registers take effect at once.
// A stalled m_axis holds the result and backs pressure into the input register.
// rst_n is asynchronous, active low; it resets control and state, not payload registers.
`include "assert_macros.svh"

module button_debounce_autorepeat_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] raw_level, [32:1] now_ms, [39:33] zero
    input  logic [bda_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] event_code
    output logic [bda_pkg::CODE_W-1:0]      m_axis_tdata,
    input  logic                            cfg_wr_en,
    input  logic [bda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bda_pkg::*;

    logic [MS_W-1:0]   debounce_reg, debounce_next;
    logic [MS_W-1:0]   first_rep_reg, first_rep_next;
    logic [CODE_W-1:0] key_code_reg, key_code_next;

    logic              in_valid_reg, in_valid_next;
    logic              in_raw_reg, in_raw_next;
    logic [NOW_W-1:0]  in_now_reg, in_now_next;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;

    logic              div_start;
    logic              div_busy;
    logic [RATE_W-1:0] repeat_interval;
    logic              in_accept;
    logic              advance;
    logic [CODE_W-1:0] event_code;
    bda_cfg_t          cfg;

    // Configuration writes
    always_comb
    begin
        debounce_next  = debounce_reg;
        first_rep_next = first_rep_reg;
        key_code_next  = key_code_reg;
        div_start      = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEBOUNCE_MS:     debounce_next  = cfg_data[MS_W-1:0];
                REG_FIRST_REPEAT_MS: first_rep_next = cfg_data[MS_W-1:0];
                REG_REPEAT_RATE:     div_start      = 1'b1;
                REG_KEY_CODE:        key_code_next  = cfg_data[CODE_W-1:0];
                default:             ;
            endcase
        end
    end

    bda_rate_div u_rate_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rate     (cfg_data[RATE_W-1:0]),
        .busy     (div_busy),
        .interval (repeat_interval)
    );

    assign cfg.debounce_ms     = debounce_reg;
    assign cfg.first_repeat_ms = first_rep_reg;
    assign cfg.repeat_interval = repeat_interval;
    assign cfg.key_code        = key_code_reg;

    // Pipeline control: input stage drains when the result stage is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !div_busy && (!in_valid_reg || advance);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    bda_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .raw_level  (in_raw_reg),
        .now_ms     (in_now_reg),
        .cfg        (cfg),
        .event_code (event_code)
    );

    // Input and result stages
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_raw_next    = in_raw_reg;
        in_now_next    = in_now_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
            in_raw_next   = s_axis_tdata[0];
            in_now_next   = s_axis_tdata[NOW_W:1];
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_code_next  = event_code;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= RST_DEBOUNCE_MS;
            first_rep_reg <= RST_FIRST_REPEAT_MS;
            key_code_reg  <= RST_KEY_CODE;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            debounce_reg  <= debounce_next;
            first_rep_reg <= first_rep_next;
            key_code_reg  <= key_code_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_raw_reg   <= in_raw_next;
        in_now_reg   <= in_now_next;
        out_code_reg <= out_code_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;

    // A waiting request moves into a free result stage by the next cycle
    `ASSERT_NEXT(a_drain, in_valid_reg && !out_valid_reg, out_valid_reg, "request stuck")
    // Result stage drained while nothing is pending leaves it empty
    `ASSERT_NEXT(a_empty, !in_valid_reg && m_axis_tready, !out_valid_reg, "result without request")
    // No request taken while the rate divide runs
    `ASSERT_NEXT(a_div_block, $rose(div_busy), !$rose(in_valid_reg), "request taken during divide")

endmodule

FILE: rtl/bda_rate_div.sv
`include "assert_macros.svh"

// Restoring divider: one quotient bit per cycle, TICKS_PER_SECOND / rate.
module bda_rate_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bda_pkg::RATE_W-1:0] rate,
    output logic                       busy,
    output logic [bda_pkg::RATE_W-1:0] interval
);
    import bda_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RATE_W-1:0]    dvd_reg, dvd_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [RATE_W-1:0]    quo_reg, quo_next;
    logic [RATE_W-1:0]    div_reg, div_next;
    logic [RATE_W-1:0]    interval_reg, interval_next;

    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 q_bit;

    // One restoring step
    assign trial = {rem_reg, dvd_reg[RATE_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign q_bit = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        div_next      = div_reg;
        interval_next = interval_reg;
        if (start)
        begin
            // a rate of zero counts as one
            div_next  = (rate == '0) ? RATE_W'(1) : rate;
            dvd_next  = TICKS_PER_SECOND;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], q_bit};
            dvd_next = {dvd_reg[RATE_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next     = 1'b0;
                interval_next = {quo_reg[RATE_W-2:0], q_bit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            div_reg      <= RST_REPEAT_RATE;
            interval_reg <= RST_REPEAT_INTERVAL;
        end
        else
        begin
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
            div_reg      <= div_next;
            interval_reg <= interval_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign interval = interval_reg;

    // Idle result is the exact integer quotient
    `ASSERT_IMPL(a_quot_low, !busy_reg, (32'(interval_reg) * 32'(div_reg)) <= 32'(TICKS_PER_SECOND), "interval too large")
    `ASSERT_IMPL(a_quot_high, !busy_reg, (32'(TICKS_PER_SECOND) - 32'(interval_reg) * 32'(div_reg)) < 32'(div_reg), "interval too small")
    `ASSERT_IMPL(a_cnt_idle, !busy_reg, cnt_reg == '0, "step count left over")

endmodule

FILE: rtl/bda_step.sv
`include "assert_macros.svh"

// Per-poll debounce and repeat logic with its state.
module bda_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       raw_level,
    input  logic [bda_pkg::NOW_W-1:0]  now_ms,
    input  bda_pkg::bda_cfg_t          cfg,
    output logic [bda_pkg::CODE_W-1:0] event_code
);
    import bda_pkg::*;

    logic              prev_raw_reg, prev_raw_next;
    logic [NOW_W-1:0]  change_stamp_reg, change_stamp_next;
    logic [CODE_W-1:0] prev_code_reg, prev_code_next;
    logic [NOW_W-1:0]  event_stamp_reg, event_stamp_next;
    logic              in_repeat_reg, in_repeat_next;

    logic [NOW_W-1:0]  stamp;
    logic [NOW_W-1:0]  diff;
    logic              held;
    logic              level;
    logic [CODE_W-1:0] code;
    logic [MS_W-1:0]   delay;
    logic [NOW_W-1:0]  due_at;
    logic              code_changed;
    logic              due;

    // Debounce: level accepted once signed age exceeds the hold time
    assign stamp = (raw_level != prev_raw_reg) ? now_ms : change_stamp_reg;
    assign diff  = now_ms - stamp;
    assign held  = !diff[NOW_W-1] && (diff > NOW_W'(cfg.debounce_ms));
    assign level = held ? raw_level : prev_raw_reg;
    assign code  = level ? cfg.key_code : '0;

    // Repeat timing, wrapping sum and unsigned compare
    assign delay        = in_repeat_reg ? MS_W'(cfg.repeat_interval) : cfg.first_repeat_ms;
    assign due_at       = event_stamp_reg + NOW_W'(delay);
    assign due          = due_at < now_ms;
    assign code_changed = (code != prev_code_reg);

    assign event_code = (code_changed || due) ? code : '0;

    always_comb
    begin
        prev_raw_next     = prev_raw_reg;
        change_stamp_next = change_stamp_reg;
        prev_code_next    = prev_code_reg;
        event_stamp_next  = event_stamp_reg;
        in_repeat_next    = in_repeat_reg;
        if (advance)
        begin
            prev_raw_next     = raw_level;
            change_stamp_next = stamp;
            prev_code_next    = code;
            if (code_changed)
            begin
                in_repeat_next   = 1'b0;
                event_stamp_next = now_ms;
            end
            else if (due)
            begin
                in_repeat_next   = 1'b1;
                event_stamp_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg     <= 1'b0;
            change_stamp_reg <= '0;
            prev_code_reg    <= '0;
            event_stamp_reg  <= '0;
            in_repeat_reg    <= 1'b0;
        end
        else
        begin
            prev_raw_reg     <= prev_raw_next;
            change_stamp_reg <= change_stamp_next;
            prev_code_reg    <= prev_code_next;
            event_stamp_reg  <= event_stamp_next;
            in_repeat_reg    <= in_repeat_next;
        end
    end

    // A raw edge restarts the debounce timer at this poll's time
    `ASSERT_NEXT(a_stamp_restart, advance && (raw_level != prev_raw_reg), change_stamp_reg == $past(now_ms), "debounce timer not restarted")
    // Any event moves the event stamp to this poll
    `ASSERT_NEXT(a_event_stamp, advance && (code_changed || due), event_stamp_reg == $past(now_ms), "event stamp not updated")
    // A nonzero event always carries the configured key code
    `ASSERT_IMPL(a_event_val, event_code != '0, event_code == cfg.key_code, "bad event code")

endmodule
